/* rtl/scsd_pkg.sv */
// ----------------------------------------------------------------------------
// scsd_pkg
// Shared codes and controller/datapath interface types for the contact set
// differ block.
// ----------------------------------------------------------------------------
package scsd_pkg;

  // input command codes
  localparam logic [2:0] CMD_CONTACT  = 3'd0;
  localparam logic [2:0] CMD_EMPTY    = 3'd1;
  localparam logic [2:0] CMD_CLEAR    = 3'd2;
  localparam logic [2:0] CMD_REM_TGT  = 3'd3;
  localparam logic [2:0] CMD_REM_TILE = 3'd4;
  localparam logic [2:0] CMD_COLLECT  = 3'd5;

  // result phase codes
  localparam logic [2:0] PH_BEGIN   = 3'd0;
  localparam logic [2:0] PH_STAY    = 3'd1;
  localparam logic [2:0] PH_END     = 3'd2;
  localparam logic [2:0] PH_COLLECT = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  // configuration register indexes
  localparam logic REG_TILE_KIND    = 1'b0;
  localparam logic REG_INVALID_KIND = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic ld_in;          // latch the accepted input item
    logic open_frame;     // frame open, new list empty, merge at start
    logic abandon;        // frame closed, new list dropped
    logic clr_stored;     // stored list emptied
    logic rd_merge;       // read old list at merge pointer
    logic rd_idx;         // read stored list at scan index
    logic mp_inc;
    logic idx_clr;
    logic idx_inc;
    logic wr_new;         // append current contact to new list if room
    logic wr_keep;        // compaction write of read entry
    logic commit_close;   // swap banks, new list becomes stored list
    logic commit_compact; // stored count takes the compaction count
    logic emit_end;
    logic emit_cur;
    logic emit_col;
    logic emit_done;
    logic last;           // run_last of the emitted result
  } scsd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;   // output register can take a result
    logic frame_open;
    logic frame_last;
    logic mp_lt_sc;
    logic mp_last;     // merge pointer is on the last stored entry
    logic idx_lt_sc;
    logic key_lt;      // read key below current key
    logic key_eq;
    logic drop_tgt;    // read entry touches current target
    logic drop_tile;   // read entry touches a tile
    logic query_ok;    // current target kind is not the invalid kind
  } scsd_stat_t;

endpackage

/* rtl/sorted_contact_set_differ_unit.sv */
// ----------------------------------------------------------------------------
// sorted_contact_set_differ_unit
// Frame-to-frame contact set difference over a sorted two-bank contact list.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_stall    command, pair key, data, frame_last
//  out      output     out_valid/out_stall  phase, pair key, data, flags
//  cfg      input      cfg_wr_en            cfg_index, cfg_data
//
//  one item at a time; every item is accepted in the idle state, then each
//  merge step is a read of the old list plus a compare; a close, compaction
//  or collect scan reads and then ends, keeps or checks each stored entry in
//  turn, and every command but a contact finishes with the done result.
//  the single memory read port sets the step rate.
//  reset is synchronous; no clearing pass, stored lists start empty.
//  a stalled output holds the sequencer on a step that emits a result until taken.
// ----------------------------------------------------------------------------
module sorted_contact_set_differ_unit #(
  parameter int DEPTH      = 32,
  parameter int ID_WIDTH   = 12,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [1:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_command,
  input  logic [1:0]            in_first_kind,
  input  logic [ID_WIDTH-1:0]   in_first_ident,
  input  logic [1:0]            in_second_kind,
  input  logic [ID_WIDTH-1:0]   in_second_ident,
  input  logic [DATA_WIDTH-1:0] in_contact_data,
  input  logic                  in_frame_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_event_phase,
  output logic [1:0]            out_first_kind,
  output logic [ID_WIDTH-1:0]   out_first_ident,
  output logic [1:0]            out_second_kind,
  output logic [ID_WIDTH-1:0]   out_second_ident,
  output logic [DATA_WIDTH-1:0] out_contact_data,
  output logic                  out_overflow,
  output logic                  out_run_last
);
  import scsd_pkg::*;

  scsd_cmd_t  cmd;
  scsd_stat_t st;

  // sequencer
  scsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .st         (st),
    .cmd        (cmd)
  );

  // memory, counters and result register
  scsd_dp #(
    .DEPTH      (DEPTH),
    .ID_WIDTH   (ID_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_first_kind    (in_first_kind),
    .in_first_ident   (in_first_ident),
    .in_second_kind   (in_second_kind),
    .in_second_ident  (in_second_ident),
    .in_contact_data  (in_contact_data),
    .in_frame_last    (in_frame_last),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_event_phase  (out_event_phase),
    .out_first_kind   (out_first_kind),
    .out_first_ident  (out_first_ident),
    .out_second_kind  (out_second_kind),
    .out_second_ident (out_second_ident),
    .out_contact_data (out_contact_data),
    .out_overflow     (out_overflow),
    .out_run_last     (out_run_last),
    .cmd              (cmd),
    .st               (st)
  );

endmodule

/* rtl/scsd_ctrl.sv */
// ----------------------------------------------------------------------------
// scsd_ctrl
// Sequencer for merge, close, compaction and collection runs.
// ----------------------------------------------------------------------------
module scsd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_command,
  output logic               in_stall,
  input  scsd_pkg::scsd_stat_t st,
  output scsd_pkg::scsd_cmd_t  cmd
);
  import scsd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_C_RD, S_C_CMP, S_CL_RD, S_CL_EM,
    S_CP_RD, S_CP_CHK, S_CO_RD, S_CO_CHK, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] op_r;

  assign in_stall = (state_r != S_IDLE);

  // state and latched command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= CMD_CONTACT;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_valid) op_r <= in_command;
    end
  end

  // command decode
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          case (in_command)
            CMD_CONTACT: begin
              cmd.open_frame = !st.frame_open;
              state_nxt      = S_C_RD;
            end
            CMD_EMPTY: begin
              cmd.abandon = !st.frame_open;
              state_nxt   = S_CL_RD;
            end
            CMD_CLEAR: begin
              cmd.abandon    = 1'b1;
              cmd.clr_stored = 1'b1;
              state_nxt      = S_DONE;
            end
            CMD_REM_TGT, CMD_REM_TILE: begin
              cmd.abandon = 1'b1;
              cmd.idx_clr = 1'b1;
              state_nxt   = S_CP_RD;
            end
            CMD_COLLECT: begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_CO_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_C_RD: begin
        cmd.rd_merge = 1'b1;
        state_nxt    = S_C_CMP;
      end
      S_C_CMP: begin
        if (st.slot_free) begin
          if (st.mp_lt_sc && st.key_lt) begin
            cmd.emit_end = 1'b1;
            cmd.mp_inc   = 1'b1;
            state_nxt    = S_C_RD;
          end else begin
            cmd.emit_cur = 1'b1;
            cmd.wr_new   = 1'b1;
            cmd.mp_inc   = st.mp_lt_sc && st.key_eq;
            // last unless the close still has stored keys to end
            cmd.last     = !st.frame_last ||
                           ((st.mp_lt_sc && st.key_eq) ? st.mp_last : !st.mp_lt_sc);
            state_nxt    = st.frame_last ? S_CL_RD : S_IDLE;
          end
        end
      end
      S_CL_RD: begin
        if (st.mp_lt_sc) begin
          cmd.rd_merge = 1'b1;
          state_nxt    = S_CL_EM;
        end else begin
          cmd.commit_close = 1'b1;
          state_nxt        = (op_r == CMD_CONTACT) ? S_IDLE : S_DONE;
        end
      end
      S_CL_EM: begin
        if (st.slot_free) begin
          cmd.emit_end = 1'b1;
          cmd.mp_inc   = 1'b1;
          cmd.last     = (op_r == CMD_CONTACT) && st.mp_last;
          state_nxt    = S_CL_RD;
        end
      end
      S_CP_RD: begin
        if (st.idx_lt_sc) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_CP_CHK;
        end else begin
          cmd.commit_compact = 1'b1;
          state_nxt          = S_DONE;
        end
      end
      S_CP_CHK: begin
        cmd.wr_keep = (op_r == CMD_REM_TILE) ? !st.drop_tile : !st.drop_tgt;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_CP_RD;
      end
      S_CO_RD: begin
        if (st.query_ok && st.idx_lt_sc) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_CO_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CO_CHK: begin
        if (!st.drop_tgt) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CO_RD;
        end else if (st.slot_free) begin
          cmd.emit_col = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_nxt    = S_CO_RD;
        end
      end
      S_DONE: begin
        if (st.slot_free) begin
          cmd.emit_done = 1'b1;
          cmd.last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/scsd_dp.sv */
// ----------------------------------------------------------------------------
// scsd_dp
// Two-bank contact memory, list counters, key compare and result register.
// ----------------------------------------------------------------------------
module scsd_dp #(
  parameter int DEPTH      = 32,
  parameter int ID_WIDTH   = 12,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [1:0]            cfg_data,
  input  logic [1:0]            in_first_kind,
  input  logic [ID_WIDTH-1:0]   in_first_ident,
  input  logic [1:0]            in_second_kind,
  input  logic [ID_WIDTH-1:0]   in_second_ident,
  input  logic [DATA_WIDTH-1:0] in_contact_data,
  input  logic                  in_frame_last,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [2:0]            out_event_phase,
  output logic [1:0]            out_first_kind,
  output logic [ID_WIDTH-1:0]   out_first_ident,
  output logic [1:0]            out_second_kind,
  output logic [ID_WIDTH-1:0]   out_second_ident,
  output logic [DATA_WIDTH-1:0] out_contact_data,
  output logic                  out_overflow,
  output logic                  out_run_last,
  input  scsd_pkg::scsd_cmd_t   cmd,
  output scsd_pkg::scsd_stat_t  st
);
  import scsd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW = 4 + 2 * ID_WIDTH;
  localparam int EW = KW + DATA_WIDTH;
  // field offsets inside an entry
  localparam int SI_LO = DATA_WIDTH;
  localparam int SK_LO = SI_LO + ID_WIDTH;
  localparam int FI_LO = SK_LO + 2;
  localparam int FK_LO = FI_LO + ID_WIDTH;

  logic [EW-1:0] mem_r [2][DEPTH];
  logic [EW-1:0] rdata_r, cur_r;
  logic          cur_last_r;
  logic [CW-1:0] sc_r, nc_r, mp_r, idx_r, wr_r;
  logic          bank_r, open_r;
  logic [1:0]    tile_r, inv_r;

  logic          nc_full;
  logic [CW:0]   mp_plus;
  logic          we;
  logic          wbank;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  assign nc_full = (nc_r == CW'(DEPTH));
  assign mp_plus = {1'b0, mp_r} + (CW + 1)'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_r <= 2'd1;
      inv_r  <= 2'd0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_TILE_KIND) tile_r <= cfg_data;
      else                            inv_r  <= cfg_data;
    end
  end

  // current item
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cur_r      <= {in_first_kind, in_first_ident, in_second_kind, in_second_ident,
                     in_contact_data};
      cur_last_r <= in_frame_last;
    end
  end

  // list counters and bank select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r   <= '0;
      nc_r   <= '0;
      mp_r   <= '0;
      idx_r  <= '0;
      wr_r   <= '0;
      bank_r <= 1'b0;
      open_r <= 1'b0;
    end else begin
      if (cmd.open_frame) begin
        open_r <= 1'b1;
        nc_r   <= '0;
        mp_r   <= '0;
      end
      if (cmd.abandon || cmd.commit_close) begin
        open_r <= 1'b0;
        nc_r   <= '0;
        mp_r   <= '0;
      end
      if (cmd.commit_close) begin
        bank_r <= ~bank_r;
        sc_r   <= nc_r;
      end
      if (cmd.clr_stored)     sc_r <= '0;
      if (cmd.commit_compact) sc_r <= wr_r;
      if (cmd.mp_inc)         mp_r <= mp_plus[CW-1:0];
      if (cmd.wr_new && !nc_full) nc_r <= nc_r + CW'(1);
      if (cmd.idx_clr) begin
        idx_r <= '0;
        wr_r  <= '0;
      end
      if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
      if (cmd.wr_keep) wr_r  <= wr_r + CW'(1);
    end
  end

  // memory write port: append to new bank or compact in stored bank
  assign we    = (cmd.wr_new && !nc_full) || cmd.wr_keep;
  assign wbank = cmd.wr_keep ? bank_r : ~bank_r;
  assign waddr = cmd.wr_keep ? wr_r[AW-1:0] : nc_r[AW-1:0];
  assign wdata = cmd.wr_keep ? rdata_r : cur_r;
  assign raddr = cmd.rd_merge ? mp_r[AW-1:0] : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem_r[wbank][waddr] <= wdata;
  end

  // registered read of the stored bank
  always_ff @(posedge clk) begin
    if (cmd.rd_merge || cmd.rd_idx) rdata_r <= mem_r[bank_r][raddr];
  end

  // status toward the controller
  always_comb begin
    st.slot_free  = !out_valid || !out_stall;
    st.frame_open = open_r;
    st.frame_last = cur_last_r;
    st.mp_lt_sc   = (mp_r < sc_r);
    st.mp_last    = (mp_plus == {1'b0, sc_r});
    st.idx_lt_sc  = (idx_r < sc_r);
    st.key_lt     = (rdata_r[EW-1:DATA_WIDTH] < cur_r[EW-1:DATA_WIDTH]);
    st.key_eq     = (rdata_r[EW-1:DATA_WIDTH] == cur_r[EW-1:DATA_WIDTH]);
    st.drop_tgt   = (rdata_r[FK_LO+:2] == cur_r[FK_LO+:2] &&
                     rdata_r[FI_LO+:ID_WIDTH] == cur_r[FI_LO+:ID_WIDTH]) ||
                    (rdata_r[SK_LO+:2] == cur_r[FK_LO+:2] &&
                     rdata_r[SI_LO+:ID_WIDTH] == cur_r[FI_LO+:ID_WIDTH]);
    st.drop_tile  = (rdata_r[FK_LO+:2] == tile_r) || (rdata_r[SK_LO+:2] == tile_r);
    st.query_ok   = (cur_r[FK_LO+:2] != inv_r);
  end

  // result register
  logic [EW-1:0] res_r;
  logic [2:0]    phase_r;
  logic          ov_r, last_r, valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit_end || cmd.emit_cur || cmd.emit_col || cmd.emit_done) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_end || cmd.emit_col) begin
      res_r   <= rdata_r;
      phase_r <= cmd.emit_end ? PH_END : PH_COLLECT;
      ov_r    <= 1'b0;
      last_r  <= cmd.last;
    end else if (cmd.emit_cur) begin
      res_r   <= cur_r;
      phase_r <= (st.mp_lt_sc && st.key_eq) ? PH_STAY : PH_BEGIN;
      ov_r    <= nc_full;
      last_r  <= cmd.last;
    end else if (cmd.emit_done) begin
      res_r   <= '0;
      phase_r <= PH_DONE;
      ov_r    <= 1'b0;
      last_r  <= 1'b1;
    end
  end

  assign out_valid        = valid_r;
  assign out_event_phase  = phase_r;
  assign out_first_kind   = res_r[FK_LO+:2];
  assign out_first_ident  = res_r[FI_LO+:ID_WIDTH];
  assign out_second_kind  = res_r[SK_LO+:2];
  assign out_second_ident = res_r[SI_LO+:ID_WIDTH];
  assign out_contact_data = res_r[DATA_WIDTH-1:0];
  assign out_overflow     = ov_r;
  assign out_run_last     = last_r;

endmodule

/* rtl/scsd_chk.sv */
// ----------------------------------------------------------------------------
// scsd_chk
// Port-level checks for the contact set differ block.
// ----------------------------------------------------------------------------
module scsd_chk #(
  parameter int ID_WIDTH   = 12,
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [2:0]            out_event_phase,
  input logic [1:0]            out_first_kind,
  input logic [ID_WIDTH-1:0]   out_first_ident,
  input logic [DATA_WIDTH-1:0] out_contact_data,
  input logic                  out_overflow,
  input logic                  out_run_last
);
  import scsd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_phase))
    else $error("stalled result changed");

  // one item in flight: a transfer in closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // done result is last and empty
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_phase == PH_DONE |->
      out_run_last && out_first_kind == 2'd0 && out_first_ident == '0 &&
      out_contact_data == '0)
    else $error("bad done result");

  // overflow only on begin or stay
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_event_phase == PH_BEGIN || out_event_phase == PH_STAY)
    else $error("overflow on wrong phase");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_contact_set_differ_unit scsd_chk #(
  .ID_WIDTH   (ID_WIDTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_scsd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_phase  (out_event_phase),
  .out_first_kind   (out_first_kind),
  .out_first_ident  (out_first_ident),
  .out_contact_data (out_contact_data),
  .out_overflow     (out_overflow),
  .out_run_last     (out_run_last)
);
